[sv/lrbf_pkg.sv]
// Shared types, constants and the arctangent table of the landmark range/bearing filter.
package lrbf_pkg;

   localparam int MAX_MARKS = 64;
   localparam int IDX_W     = $clog2(MAX_MARKS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int POS_W     = 24;
   localparam int QUAT_W    = 16;
   localparam int ANG_W     = 16;
   localparam int RANGE_W   = 24;
   localparam int BEAR_W    = 15;
   localparam int COLOR_W   = 2;
   localparam int CFG_W     = 24;
   localparam int CFG_IDX_W = 2;
   localparam int CORDIC_STEPS = 20;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_BEARING = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_2     = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE_3     = 2'd3;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RST   = 24'd2560;
   localparam logic [BEAR_W-1:0]  MAX_BEARING_RST = 15'd10923;

   localparam logic [COLOR_W-1:0] COLOR_UNKNOWN = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_BLUE    = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [COLOR_W-1:0]      color;
   } mark_type;

   // Arctangent of 2^-i as a 32-bit binary angle (2^32 per turn).
   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

[sv/lrbf_chan_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface lrbf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             mode;
   logic signed [lrbf_pkg::POS_W-1:0]      mark_x;
   logic signed [lrbf_pkg::POS_W-1:0]      mark_y;
   logic [lrbf_pkg::COLOR_W-1:0]           mark_color;
   logic signed [lrbf_pkg::POS_W-1:0]      pose_x;
   logic signed [lrbf_pkg::POS_W-1:0]      pose_y;
   logic signed [lrbf_pkg::QUAT_W-1:0]     quat_x;
   logic signed [lrbf_pkg::QUAT_W-1:0]     quat_y;
   logic signed [lrbf_pkg::QUAT_W-1:0]     quat_z;
   logic signed [lrbf_pkg::QUAT_W-1:0]     quat_w;

   modport source (output valid, mode, mark_x, mark_y, mark_color, pose_x, pose_y,
                   quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, mode, mark_x, mark_y, mark_color, pose_x, pose_y,
                   quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface lrbf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 visible;
   logic [lrbf_pkg::RANGE_W-1:0]         range_out;
   logic signed [lrbf_pkg::ANG_W-1:0]    bearing_out;
   logic [lrbf_pkg::COLOR_W-1:0]         color_out;
   logic                                 last;

   modport source (output valid, visible, range_out, bearing_out, color_out, last,
                   input ready);
   modport sink   (input valid, visible, range_out, bearing_out, color_out, last,
                   output ready);
endinterface

[sv/landmark_range_bearing_filter.sv]
// Landmark table with a range and bearing field-of-view query, top level.
//
// A clear or append word gives no response and leaves the request side ready
// for the next word. A pose query word first forms the quaternion terms on the
// single shared multiplier, then the yaw by CORDIC when it is not in gimbal
// lock, then for every stored landmark a fetch, two squares on the multiplier,
// up to a dozen normalizing shifts and 20 CORDIC steps; an accepted landmark
// also takes 25 square-root steps. The CORDIC loop and the bit-serial square
// root set the query time, which also grows while the response side holds
// off. The request side is ready only while the sequencer is idle. Responses
// come in table order; the last one of a query is marked, and a query that
// sees nothing answers with a single empty word. The user must write range
// and bearing limits on the csr port only between queries; the block itself
// does not enforce this.
module landmark_range_bearing_filter (
   input  logic                               clock,
   input  logic                               reset,
   lrbf_req_if.sink                           req_ch,
   lrbf_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [lrbf_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [lrbf_pkg::CFG_W-1:0]         csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_QMUL, S_YAWDEC, S_FETCH, S_DIFF, S_SQX, S_SQY, S_SQS,
      S_CSTART, S_NORM, S_ITER, S_CEND, S_TEST, S_SQRT, S_EMIT, S_FINAL
   } state_type;

   localparam int CW = 40;
   localparam int AW = 36;

   state_type state_ff;

   logic [lrbf_pkg::RANGE_W-1:0] max_range_ff;
   logic [lrbf_pkg::BEAR_W-1:0]  max_bearing_ff;
   logic [lrbf_pkg::CNT_W-1:0]   count_ff;
   logic [lrbf_pkg::CNT_W-1:0]   idx_ff;

   lrbf_pkg::mark_type mark_mem [lrbf_pkg::MAX_MARKS];
   lrbf_pkg::mark_type rd_ff;

   logic signed [lrbf_pkg::POS_W-1:0]  px_ff, py_ff;
   logic signed [lrbf_pkg::QUAT_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic [3:0]                         cnt_ff;
   logic signed [49:0]                 prod_ff;
   logic signed [AW-1:0]               d_ff, a_ff, t_ff, b_ff;
   logic [47:0]                        lim_ff;

   logic signed [24:0]                 dx_ff, dy_ff;
   logic [lrbf_pkg::COLOR_W-1:0]       color_ff;
   logic [49:0]                        s_ff;

   logic signed [CW-1:0]               cx_ff, cy_ff;
   logic [31:0]                        z_ff;
   logic [4:0]                         it_ff;
   logic                               for_yaw_ff;
   logic [lrbf_pkg::ANG_W-1:0]         yaw_ff, bear_ff;

   logic [49:0]                        sq_v_ff;
   logic [50:0]                        sq_res_ff;
   logic [49:0]                        sq_bit_ff;

   logic                               pend_ff;
   logic [lrbf_pkg::RANGE_W-1:0]       pend_range_ff;
   logic [lrbf_pkg::ANG_W-1:0]         pend_bear_ff;
   logic [lrbf_pkg::COLOR_W-1:0]       pend_color_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_visible_ff;
   logic [lrbf_pkg::RANGE_W-1:0]       rsp_range_ff;
   logic [lrbf_pkg::ANG_W-1:0]         rsp_bear_ff;
   logic [lrbf_pkg::COLOR_W-1:0]       rsp_color_ff;
   logic                               rsp_last_ff;

   // Shared multiplier: operands picked by the sequencer, product registered.
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_QMUL: begin
            case (cnt_ff)
               4'd0: begin mul_a = 25'(qx_ff); mul_b = 25'(qx_ff); end
               4'd1: begin mul_a = 25'(qy_ff); mul_b = 25'(qy_ff); end
               4'd2: begin mul_a = 25'(qz_ff); mul_b = 25'(qz_ff); end
               4'd3: begin mul_a = 25'(qw_ff); mul_b = 25'(qw_ff); end
               4'd4: begin mul_a = 25'(qx_ff); mul_b = 25'(qz_ff); end
               4'd5: begin mul_a = 25'(qw_ff); mul_b = 25'(qy_ff); end
               4'd6: begin mul_a = 25'(qx_ff); mul_b = 25'(qy_ff); end
               4'd7: begin mul_a = 25'(qw_ff); mul_b = 25'(qz_ff); end
               4'd8: begin
                  mul_a = $signed({1'b0, max_range_ff});
                  mul_b = $signed({1'b0, max_range_ff});
               end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         S_SQX: begin mul_a = dx_ff; mul_b = dx_ff; end
         S_SQY: begin mul_a = dy_ff; mul_b = dy_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Derived values used by the sequencer.
   logic signed [AW-1:0]  p36;
   logic signed [AW:0]    t2;
   logic [AW:0]           t2_abs;
   logic                  no_yaw;
   logic [CW-1:0]         cy_abs;
   logic [CW-1:0]         cmax;
   logic signed [CW-1:0]  xs, ys;
   logic [31:0]           z_rnd;
   logic [lrbf_pkg::ANG_W-1:0] ang;
   logic signed [16:0]    bs;
   logic [16:0]           ba;
   logic [50:0]           sq_try;
   logic [lrbf_pkg::RANGE_W-1:0] r_sat;
   logic                  out_free;
   logic                  rsp_load;
   logic                  req_fire;
   logic [lrbf_pkg::COLOR_W-1:0] col_out;

   always_comb begin
      p36     = prod_ff[AW-1:0];
      t2      = {t_ff, 1'b0};
      t2_abs  = t2[AW] ? $unsigned(-t2) : $unsigned(t2);
      no_yaw  = (d_ff == '0) || (t2_abs >= {1'b0, d_ff});
      cy_abs  = cy_ff[CW-1] ? $unsigned(-cy_ff) : $unsigned(cy_ff);
      cmax    = ($unsigned(cx_ff) > cy_abs) ? $unsigned(cx_ff) : cy_abs;
      xs      = cx_ff >>> it_ff;
      ys      = cy_ff >>> it_ff;
      z_rnd   = z_ff + 32'h0000_8000;
      ang     = z_rnd[31:16];
      bs      = 17'($signed(bear_ff));
      ba      = bs[16] ? 17'(-bs) : 17'(bs);
      sq_try  = sq_res_ff + 51'(sq_bit_ff);
      r_sat   = (sq_res_ff > 51'(24'hFF_FFFF)) ? 24'hFF_FFFF : sq_res_ff[23:0];
      out_free = !rsp_valid_ff || rsp_ch.ready;
      // The response register takes a new word in this cycle.
      rsp_load = ((state_ff == S_EMIT) && pend_ff && out_free) ||
                 ((state_ff == S_FINAL) && out_free);
      req_fire = req_ch.valid && req_ch.ready;
      col_out  = (color_ff > lrbf_pkg::COLOR_BLUE) ? lrbf_pkg::COLOR_UNKNOWN : color_ff;
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   // Landmark table: written on append while not full, read through a register at the scan index.
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.mode == lrbf_pkg::MODE_APPEND &&
          count_ff < lrbf_pkg::CNT_W'(lrbf_pkg::MAX_MARKS)) begin
         mark_mem[count_ff[lrbf_pkg::IDX_W-1:0]] <=
            '{x: req_ch.mark_x, y: req_ch.mark_y, color: req_ch.mark_color};
      end
      rd_ff <= mark_mem[idx_ff[lrbf_pkg::IDX_W-1:0]];
   end

   // Control and status registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff   <= lrbf_pkg::MAX_RANGE_RST;
         max_bearing_ff <= lrbf_pkg::MAX_BEARING_RST;
      end else if (csr_we) begin
         case (csr_index)
            lrbf_pkg::REG_MAX_RANGE:   max_range_ff   <= csr_wdata;
            lrbf_pkg::REG_MAX_BEARING: max_bearing_ff <= csr_wdata[lrbf_pkg::BEAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer with its datapath and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_ch.mode)
                     lrbf_pkg::MODE_CLEAR: count_ff <= '0;
                     lrbf_pkg::MODE_APPEND: begin
                        if (count_ff < lrbf_pkg::CNT_W'(lrbf_pkg::MAX_MARKS)) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     lrbf_pkg::MODE_QUERY: begin
                        px_ff <= req_ch.pose_x;
                        py_ff <= req_ch.pose_y;
                        qx_ff <= req_ch.quat_x;
                        qy_ff <= req_ch.quat_y;
                        qz_ff <= req_ch.quat_z;
                        qw_ff <= req_ch.quat_w;
                        cnt_ff <= '0;
                        d_ff <= '0;
                        a_ff <= '0;
                        t_ff <= '0;
                        b_ff <= '0;
                        pend_ff <= 1'b0;
                        state_ff <= S_QMUL;
                     end
                     default: ;
                  endcase
               end
            end
            S_QMUL: begin
               prod_ff <= mul_p;
               cnt_ff  <= cnt_ff + 1'b1;
               // Accumulate the product formed in the previous cycle.
               case (cnt_ff)
                  4'd1: begin d_ff <= d_ff + p36; a_ff <= a_ff + p36; end
                  4'd2: begin d_ff <= d_ff + p36; a_ff <= a_ff - p36; end
                  4'd3: begin d_ff <= d_ff + p36; a_ff <= a_ff - p36; end
                  4'd4: begin d_ff <= d_ff + p36; a_ff <= a_ff + p36; end
                  4'd5: t_ff <= t_ff + p36;
                  4'd6: t_ff <= t_ff - p36;
                  4'd7: b_ff <= b_ff + p36;
                  4'd8: b_ff <= b_ff + p36;
                  4'd9: begin
                     lim_ff   <= prod_ff[47:0];
                     state_ff <= S_YAWDEC;
                  end
                  default: ;
               endcase
            end
            S_YAWDEC: begin
               // Gimbal lock and the zero quaternion both leave yaw at zero.
               if (no_yaw) begin
                  yaw_ff   <= '0;
                  idx_ff   <= '0;
                  state_ff <= S_FETCH;
               end else begin
                  cx_ff      <= CW'(a_ff);
                  cy_ff      <= CW'($signed({b_ff, 1'b0}));
                  for_yaw_ff <= 1'b1;
                  state_ff   <= S_CSTART;
               end
            end
            S_FETCH: begin
               if (idx_ff == count_ff) begin
                  state_ff <= S_FINAL;
               end else begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               dx_ff    <= 25'(rd_ff.x) - 25'(px_ff);
               dy_ff    <= 25'(rd_ff.y) - 25'(py_ff);
               color_ff <= rd_ff.color;
               state_ff <= S_SQX;
            end
            S_SQX: begin
               prod_ff  <= mul_p;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               prod_ff  <= mul_p;
               s_ff     <= prod_ff[49:0];
               state_ff <= S_SQS;
            end
            S_SQS: begin
               s_ff       <= s_ff + prod_ff[49:0];
               cx_ff      <= CW'(dx_ff);
               cy_ff      <= CW'(dy_ff);
               for_yaw_ff <= 1'b0;
               state_ff   <= S_CSTART;
            end
            S_CSTART: begin
               if (cx_ff == '0 && cy_ff == '0) begin
                  // Rounds to an angle of zero.
                  z_ff     <= 32'hFFFF_8000;
                  state_ff <= S_CEND;
               end else begin
                  if (cx_ff < 0) begin
                     cx_ff <= -cx_ff;
                     cy_ff <= -cy_ff;
                     z_ff  <= 32'h8000_0000;
                  end else begin
                     z_ff  <= '0;
                  end
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (cmax < CW'(1) << 25) begin
                  cx_ff <= cx_ff <<< 4;
                  cy_ff <= cy_ff <<< 4;
               end else if (cmax < CW'(1) << 29) begin
                  cx_ff <= cx_ff <<< 1;
                  cy_ff <= cy_ff <<< 1;
               end else begin
                  it_ff    <= '0;
                  state_ff <= S_ITER;
               end
            end
            S_ITER: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  z_ff  <= z_ff + lrbf_pkg::atan_lut(it_ff);
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  z_ff  <= z_ff - lrbf_pkg::atan_lut(it_ff);
               end
               it_ff <= it_ff + 1'b1;
               if (it_ff == 5'(lrbf_pkg::CORDIC_STEPS - 1)) begin
                  state_ff <= S_CEND;
               end
            end
            S_CEND: begin
               if (for_yaw_ff) begin
                  yaw_ff   <= ang;
                  idx_ff   <= '0;
                  state_ff <= S_FETCH;
               end else begin
                  bear_ff  <= ang - yaw_ff;
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               if (s_ff > 50'(lim_ff) || ba > 17'(max_bearing_ff)) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_FETCH;
               end else begin
                  sq_v_ff   <= s_ff;
                  sq_res_ff <= '0;
                  sq_bit_ff <= 50'(1) << 48;
                  state_ff  <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (51'(sq_v_ff) >= sq_try) begin
                  sq_v_ff   <= 50'(51'(sq_v_ff) - sq_try);
                  sq_res_ff <= (sq_res_ff >> 1) + 51'(sq_bit_ff);
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff[0]) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               // A hit is held back one place so the final one can carry last.
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_visible_ff <= 1'b1;
                     rsp_range_ff   <= pend_range_ff;
                     rsp_bear_ff    <= pend_bear_ff;
                     rsp_color_ff   <= pend_color_ff;
                     rsp_last_ff    <= 1'b0;
                  end
                  pend_ff       <= 1'b1;
                  pend_range_ff <= r_sat;
                  pend_bear_ff  <= bear_ff;
                  pend_color_ff <= col_out;
                  idx_ff        <= idx_ff + 1'b1;
                  state_ff      <= S_FETCH;
               end
            end
            S_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_visible_ff <= pend_ff;
                  rsp_range_ff   <= pend_ff ? pend_range_ff : '0;
                  rsp_bear_ff    <= pend_ff ? pend_bear_ff : '0;
                  rsp_color_ff   <= pend_ff ? pend_color_ff : lrbf_pkg::COLOR_UNKNOWN;
                  rsp_last_ff    <= 1'b1;
                  pend_ff        <= 1'b0;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.visible     = rsp_visible_ff;
   assign rsp_ch.range_out   = rsp_range_ff;
   assign rsp_ch.bearing_out = rsp_bear_ff;
   assign rsp_ch.color_out   = rsp_color_ff;
   assign rsp_ch.last        = rsp_last_ff;

`ifndef ASSERT_OFF
   // The fill count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lrbf_pkg::CNT_W'(lrbf_pkg::MAX_MARKS))
      else $error("landmark count beyond table size");

   // A clear word empties the table in the next cycle.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.mode == lrbf_pkg::MODE_CLEAR) |=> count_ff == '0)
      else $error("clear word did not empty the table");

   // An empty answer is always the final word of its query.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_visible_ff) |-> rsp_last_ff)
      else $error("empty response without last");

   // The scan index never runs past the fill count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> idx_ff <= count_ff)
      else $error("scan index beyond fill count");
`endif

endmodule
